// ----- hw/rtl/fact_lnd_pkg.sv -----
// ----------------------------------------------------------------------------
// fact_lnd_pkg
// Shared types and constants of the last nonzero factorial digit block.
// ----------------------------------------------------------------------------
package fact_lnd_pkg;

   // default limits handed to the top level
   localparam int MAX_N_DEF      = 65535;
   localparam int MAX_PRIMES_DEF = 3;

   // field widths
   localparam int COUNT_W = 16;
   localparam int RADIX_W = 6;
   localparam int VALUE_W = 6;
   localparam int CHAR_W  = 7;
   localparam int REQ_W   = 24;
   localparam int RSP_W   = 16;

   // quotient bits resolved per divider cycle
   localparam int DIV_STEPS = 4;

   // character constants
   localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'd48;
   localparam logic [CHAR_W-1:0]  CHAR_ALPHA = 7'd65;
   localparam logic [VALUE_W-1:0] DIGIT_TEN  = 6'd10;

   // largest trial factor plus one
   localparam logic [6:0] TRIAL_END = 7'd64;

   // datapath operations
   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_FDIV,
      OP_FSTEP,
      OP_FNEXT,
      OP_MINIT,
      OP_TLOAD,
      OP_SDIV,
      OP_SSTEP,
      OP_SNEXT,
      OP_RDIV,
      OP_PDIV,
      OP_PSET,
      OP_CINIT,
      OP_QDIV,
      OP_QSET,
      OP_XINIT,
      OP_XLOAD,
      OP_BSET,
      OP_XNEXT,
      OP_VDIV,
      OP_VSET,
      OP_BDIV,
      OP_BSQ,
      OP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
      logic rem_zero;
      logic small_radix;
      logic fact_done;
      logic n_zero;
      logic j_end;
      logic i_done;
      logic ex_zero;
      logic ex_odd;
      logic out_free;
   } dp_status_type;

endpackage

// ----- hw/rtl/fact_lnd_div.sv -----
// ----------------------------------------------------------------------------
// fact_lnd_div
// Restoring divider, wide dividend by six-bit divisor, a few bits per cycle.
// ----------------------------------------------------------------------------
module fact_lnd_div
   import fact_lnd_pkg::*;
#(
   parameter int DW = 20
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [5:0]    divisor,
   output logic          done,
   output logic [DW-1:0] quot,
   output logic [5:0]    rem
);

   localparam int CYC = (DW + DIV_STEPS - 1) / DIV_STEPS;
   localparam int PW  = CYC * DIV_STEPS;
   localparam int CW  = $clog2(CYC + 1);

   logic          busy_ff;
   logic          done_ff;
   logic [CW-1:0] cnt_ff;
   logic [PW-1:0] quo_ff;
   logic [PW-1:0] quo_in;
   logic [6:0]    rem_ff;
   logic [6:0]    rem_in;
   logic [5:0]    d_ff;

   // several shift-compare-subtract steps per cycle
   always_comb begin
      logic [6:0]    r;
      logic [PW-1:0] q;
      r = rem_ff;
      q = quo_ff;
      for (int k = 0; k < DIV_STEPS; k++) begin
         r = {r[5:0], q[PW-1]};
         q = {q[PW-2:0], 1'b0};
         if (r >= {1'b0, d_ff}) begin
            r    = r - {1'b0, d_ff};
            q[0] = 1'b1;
         end
      end
      rem_in = r;
      quo_in = q;
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !start && busy_ff && (cnt_ff == CW'(1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(CYC);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= PW'(dividend);
         rem_ff <= '0;
         d_ff   <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done = done_ff;
   assign quot = quo_ff[DW-1:0];
   assign rem  = rem_ff[5:0];

endmodule

// ----- hw/rtl/fact_lnd_dpath.sv -----
// ----------------------------------------------------------------------------
// fact_lnd_dpath
// Registers, operand selection and result register of the digit block.
// ----------------------------------------------------------------------------
module fact_lnd_dpath
   import fact_lnd_pkg::*;
#(
   parameter int MAX_N      = MAX_N_DEF,
   parameter int MAX_PRIMES = MAX_PRIMES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   output dp_status_type      status,
   input  logic [REQ_W-1:0]   req_tdata,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RSP_W-1:0]   rsp_tdata
);

   localparam int NW = $clog2(MAX_N + 1);
   localparam int DW = (NW > 12) ? NW : 12;
   localparam int JW = $clog2(MAX_PRIMES + 1);
   localparam int IW = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;

   logic [NW-1:0]   n_ff;
   logic [5:0]      b_ff;
   logic [5:0]      brem_ff;
   logic [6:0]      f_ff;
   logic [2:0]      e_ff;
   logic [JW-1:0]   pc_ff;
   logic [5:0]      p_ff [MAX_PRIMES];
   logic [2:0]      x_ff [MAX_PRIMES];
   logic [NW-1:0]   cnt_ff [MAX_PRIMES];
   logic [5:0]      prod_ff;
   logic [NW:0]     i_ff;
   logic [NW-1:0]   t_ff;
   logic [JW-1:0]   j_ff;
   logic [NW-1:0]   m_ff;
   logic [NW-1:0]   ex_ff;
   logic [5:0]      base_ff;
   logic [5:0]      val_ff;
   logic            rsp_valid_ff;
   logic [RSP_W-1:0] rsp_data_ff;

   logic [COUNT_W-1:0] req_n;
   logic [RADIX_W-1:0] req_b;
   logic [NW-1:0]      n_sat;
   logic [IW-1:0]      jx;
   logic [IW-1:0]      px;

   logic          div_start;
   logic [DW-1:0] div_a;
   logic [5:0]    div_d;
   logic          div_done;
   logic [DW-1:0] div_q;
   logic [5:0]    div_r;

   logic [11:0]     mul_pr;
   logic [11:0]     mul_vb;
   logic [11:0]     mul_bb;
   logic [NW+2:0]   mul_em;
   logic [CHAR_W-1:0] digit_char;

   assign req_n = req_tdata[COUNT_W-1:0];
   assign req_b = req_tdata[COUNT_W+RADIX_W-1:COUNT_W];
   assign n_sat = (32'(req_n) > 32'(MAX_N)) ? NW'(MAX_N) : NW'(req_n);
   assign jx    = j_ff[IW-1:0];
   assign px    = pc_ff[IW-1:0];

   // small products, three feeding the divider and one the surplus exponent
   assign mul_pr = prod_ff * div_r;
   assign mul_vb = val_ff * base_ff;
   assign mul_bb = base_ff * base_ff;
   assign mul_em = x_ff[jx] * m_ff;

   // divider operands
   always_comb begin
      div_start = 1'b0;
      div_a     = '0;
      div_d     = b_ff;
      case (cmd.op)
         OP_FDIV: begin
            div_start = 1'b1;
            div_a     = DW'(brem_ff);
            div_d     = f_ff[5:0];
         end
         OP_SDIV: begin
            div_start = 1'b1;
            div_a     = DW'(t_ff);
            div_d     = p_ff[jx];
         end
         OP_RDIV: begin
            div_start = 1'b1;
            div_a     = DW'(t_ff);
         end
         OP_PDIV: begin
            div_start = 1'b1;
            div_a     = DW'(mul_pr);
         end
         OP_QDIV: begin
            div_start = 1'b1;
            div_a     = DW'(cnt_ff[jx]);
            div_d     = {3'b000, x_ff[jx]};
         end
         OP_XLOAD: begin
            div_start = 1'b1;
            div_a     = DW'(p_ff[jx]);
         end
         OP_VDIV: begin
            div_start = 1'b1;
            div_a     = DW'(mul_vb);
         end
         OP_BDIV: begin
            div_start = 1'b1;
            div_a     = DW'(mul_bb);
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   fact_lnd_div #(.DW(DW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_d),
      .done     (div_done),
      .quot     (div_q),
      .rem      (div_r)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= '0;
         prod_ff      <= 6'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.op == OP_EMIT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (cmd.op)
            OP_LOAD: begin
               pc_ff <= '0;
            end
            OP_FNEXT: begin
               if (e_ff != 3'd0 && 32'(pc_ff) < 32'(MAX_PRIMES)) begin
                  pc_ff <= pc_ff + 1'b1;
               end
            end
            OP_MINIT: begin
               prod_ff <= 6'd1;
            end
            OP_PSET: begin
               prod_ff <= div_r;
            end
            default: begin
               pc_ff <= pc_ff;
            end
         endcase
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            n_ff    <= n_sat;
            b_ff    <= req_b;
            brem_ff <= req_b;
            f_ff    <= 7'd2;
            e_ff    <= 3'd0;
            val_ff  <= '0;
         end
         OP_FSTEP: begin
            e_ff    <= e_ff + 1'b1;
            brem_ff <= div_q[5:0];
         end
         OP_FNEXT: begin
            if (e_ff != 3'd0 && 32'(pc_ff) < 32'(MAX_PRIMES)) begin
               p_ff[px] <= f_ff[5:0];
               x_ff[px] <= e_ff;
            end
            e_ff <= 3'd0;
            f_ff <= f_ff + 1'b1;
         end
         OP_MINIT: begin
            for (int k = 0; k < MAX_PRIMES; k++) begin
               cnt_ff[k] <= '0;
            end
            i_ff <= (NW+1)'(1);
         end
         OP_TLOAD: begin
            t_ff <= i_ff[NW-1:0];
            j_ff <= '0;
         end
         OP_SSTEP: begin
            cnt_ff[jx] <= cnt_ff[jx] + 1'b1;
            t_ff       <= div_q[NW-1:0];
         end
         OP_SNEXT: begin
            j_ff <= j_ff + 1'b1;
         end
         OP_PSET: begin
            i_ff <= i_ff + 1'b1;
         end
         OP_CINIT: begin
            j_ff <= '0;
         end
         OP_QSET: begin
            if (j_ff == '0 || div_q[NW-1:0] < m_ff) begin
               m_ff <= div_q[NW-1:0];
            end
            j_ff <= j_ff + 1'b1;
         end
         OP_XINIT: begin
            j_ff   <= '0;
            val_ff <= prod_ff;
         end
         OP_XLOAD: begin
            ex_ff <= cnt_ff[jx] - mul_em[NW-1:0];
         end
         OP_BSET: begin
            base_ff <= div_r;
         end
         OP_XNEXT: begin
            j_ff <= j_ff + 1'b1;
         end
         OP_VSET: begin
            // odd bit consumed, the square follows unless the exponent is now zero
            val_ff   <= div_r;
            ex_ff[0] <= 1'b0;
         end
         OP_BSQ: begin
            base_ff <= div_r;
            ex_ff   <= ex_ff >> 1;
         end
         OP_EMIT: begin
            rsp_data_ff <= RSP_W'({digit_char, val_ff});
         end
         default: begin
            t_ff <= t_ff;
         end
      endcase
   end

   // ASCII form of the digit
   assign digit_char = (val_ff < DIGIT_TEN) ? (CHAR_ZERO + CHAR_W'(val_ff))
                     : (CHAR_ALPHA + CHAR_W'(val_ff) - CHAR_W'(DIGIT_TEN));

   // status towards the controller
   assign status.div_done    = div_done;
   assign status.rem_zero    = (div_r == 6'd0);
   assign status.small_radix = (req_b < 6'd2);
   assign status.fact_done   = (brem_ff <= 6'd1) || (f_ff == TRIAL_END);
   assign status.n_zero      = (n_ff == '0);
   assign status.j_end       = (j_ff == pc_ff);
   assign status.i_done      = (i_ff > {1'b0, n_ff});
   assign status.ex_zero     = (ex_ff == '0);
   assign status.ex_odd      = ex_ff[0];
   assign status.out_free    = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- hw/rtl/fact_lnd_ctrl.sv -----
// ----------------------------------------------------------------------------
// fact_lnd_ctrl
// Sequencer: radix factoring, product loop, surplus powers, result hand-off.
// ----------------------------------------------------------------------------
module fact_lnd_ctrl
   import fact_lnd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [17:0] {
      S_IDLE  = 18'h00001,
      S_FDIV  = 18'h00002,
      S_FWAIT = 18'h00004,
      S_FCHK  = 18'h00008,
      S_TLOAD = 18'h00010,
      S_STRIP = 18'h00020,
      S_SWAIT = 18'h00040,
      S_RWAIT = 18'h00080,
      S_PWAIT = 18'h00100,
      S_ICHK  = 18'h00200,
      S_CINIT = 18'h00400,
      S_QCHK  = 18'h00800,
      S_QWAIT = 18'h01000,
      S_XCHK  = 18'h02000,
      S_BWAIT = 18'h04000,
      S_POW   = 18'h08000,
      S_VWAIT = 18'h10000,
      S_BSQW  = 18'h20000
   } state_type;

   // a pending result is marked by fin_ff while the state rests in idle
   localparam state_type S_FIN_CODE = S_IDLE;

   state_type state_ff;
   state_type state_in;
   logic      fin_ff;
   logic      fin_in;

   // next state and command
   always_comb begin
      state_in = state_ff;
      fin_in   = fin_ff;
      cmd.op   = OP_NONE;
      if (fin_ff) begin
         if (status.out_free) begin
            cmd.op   = OP_EMIT;
            fin_in   = 1'b0;
            state_in = S_FIN_CODE;
         end
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  cmd.op = OP_LOAD;
                  if (status.small_radix) begin
                     fin_in = 1'b1;
                  end else begin
                     state_in = S_FDIV;
                  end
               end
            end
            S_FDIV: begin
               cmd.op   = OP_FDIV;
               state_in = S_FWAIT;
            end
            S_FWAIT: begin
               if (status.div_done) begin
                  if (status.rem_zero) begin
                     cmd.op   = OP_FSTEP;
                     state_in = S_FDIV;
                  end else begin
                     cmd.op   = OP_FNEXT;
                     state_in = S_FCHK;
                  end
               end
            end
            S_FCHK: begin
               if (status.fact_done) begin
                  cmd.op   = OP_MINIT;
                  state_in = status.n_zero ? S_CINIT : S_TLOAD;
               end else begin
                  cmd.op   = OP_FDIV;
                  state_in = S_FWAIT;
               end
            end
            S_TLOAD: begin
               cmd.op   = OP_TLOAD;
               state_in = S_STRIP;
            end
            S_STRIP: begin
               if (status.j_end) begin
                  cmd.op   = OP_RDIV;
                  state_in = S_RWAIT;
               end else begin
                  cmd.op   = OP_SDIV;
                  state_in = S_SWAIT;
               end
            end
            S_SWAIT: begin
               if (status.div_done) begin
                  cmd.op   = status.rem_zero ? OP_SSTEP : OP_SNEXT;
                  state_in = S_STRIP;
               end
            end
            S_RWAIT: begin
               if (status.div_done) begin
                  cmd.op   = OP_PDIV;
                  state_in = S_PWAIT;
               end
            end
            S_PWAIT: begin
               if (status.div_done) begin
                  cmd.op   = OP_PSET;
                  state_in = S_ICHK;
               end
            end
            S_ICHK: begin
               if (status.i_done) begin
                  cmd.op   = OP_CINIT;
                  state_in = S_QCHK;
               end else begin
                  cmd.op   = OP_TLOAD;
                  state_in = S_STRIP;
               end
            end
            S_CINIT: begin
               cmd.op   = OP_CINIT;
               state_in = S_QCHK;
            end
            S_QCHK: begin
               if (status.j_end) begin
                  cmd.op   = OP_XINIT;
                  state_in = S_XCHK;
               end else begin
                  cmd.op   = OP_QDIV;
                  state_in = S_QWAIT;
               end
            end
            S_QWAIT: begin
               if (status.div_done) begin
                  cmd.op   = OP_QSET;
                  state_in = S_QCHK;
               end
            end
            S_XCHK: begin
               if (status.j_end) begin
                  fin_in   = 1'b1;
                  state_in = S_FIN_CODE;
               end else begin
                  cmd.op   = OP_XLOAD;
                  state_in = S_BWAIT;
               end
            end
            S_BWAIT: begin
               if (status.div_done) begin
                  cmd.op   = OP_BSET;
                  state_in = S_POW;
               end
            end
            S_POW: begin
               if (status.ex_zero) begin
                  cmd.op   = OP_XNEXT;
                  state_in = S_XCHK;
               end else if (status.ex_odd) begin
                  cmd.op   = OP_VDIV;
                  state_in = S_VWAIT;
               end else begin
                  cmd.op   = OP_BDIV;
                  state_in = S_BSQW;
               end
            end
            S_VWAIT: begin
               if (status.div_done) begin
                  cmd.op   = OP_VSET;
                  state_in = S_POW;
               end
            end
            S_BSQW: begin
               if (status.div_done) begin
                  cmd.op   = OP_BSQ;
                  state_in = S_POW;
               end
            end
            default: begin
               state_in = S_IDLE;
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fin_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         fin_ff   <= fin_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE) && !fin_ff;

endmodule

// ----- hw/rtl/factorial_last_nonzero_digit.sv -----
// ----------------------------------------------------------------------------
// factorial_last_nonzero_digit
// Last nonzero digit of n! in base b, as a value and an ASCII character.
//
//   channel   direction   tdata fields (lowest bit first)
//   req_      in          count_n[15:0], radix[21:16], zero pad to 24 bits
//   rsp_      out         digit_value[5:0], digit_char[12:6], pad to 16 bits
//
// One request at a time; every division runs through one shared divider that
// resolves four quotient bits a cycle. Each product term takes one division
// for every prime of the radix and every factor stripped, plus one reduction
// and one product division; factoring the radix takes one division per trial
// factor and per factor found, and each surplus power about one squaring
// division per exponent bit plus one per set bit. A radix below two: digit 0.
// Synchronous active-high reset. A finished result waits in the output
// register until taken; the next request is accepted once the result is in it.
// ----------------------------------------------------------------------------
module factorial_last_nonzero_digit
   import fact_lnd_pkg::*;
#(
   parameter int MAX_N      = MAX_N_DEF,
   parameter int MAX_PRIMES = MAX_PRIMES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // count_n[15:0], radix[21:16]
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // digit_value[5:0], digit_char[12:6]
);

   dp_cmd_type    cmd;
   dp_status_type status;

   fact_lnd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   fact_lnd_dpath #(
      .MAX_N      (MAX_N),
      .MAX_PRIMES (MAX_PRIMES)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
